### hdl/olar_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ordered list block
// no dependencies; used by the interfaces, the cell, the chain and the top level

package olar_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SHOW   = 2'd2;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_REMOVED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_LISTED    = 3'd5;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_SHOW
    } olar_state_t;

endpackage

### hdl/olar_req_if.sv
`timescale 1ns / 1ps
// command channel: valid/ready handshake with command and value
// depends on olar_pkg for the data width

interface olar_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        command;
    logic signed [olar_pkg::DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

### hdl/olar_rsp_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready handshake with status, element and last
// depends on olar_pkg for the data width

interface olar_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        status;
    logic signed [olar_pkg::DATA_W-1:0] element;
    logic                              last;

    modport source (output valid, output status, output element, output last, input ready);
    modport sink (input valid, input status, input element, input last, output ready);
endinterface

### hdl/olar_cell.sv
`timescale 1ns / 1ps
// one list slot: holds a value, compares it, and loads the command value, its neighbor or the head
// depends on olar_pkg

module olar_cell (
    input  logic                                clk,
    input  olar_pkg::cell_ctrl_t                ctrl,
    input  logic [olar_pkg::IDX_W-1:0]          idx,
    input  logic signed [olar_pkg::DATA_W-1:0]  next_val,
    input  logic signed [olar_pkg::DATA_W-1:0]  head_val,
    input  logic                                found_in,
    output logic                                found_out,
    output logic signed [olar_pkg::DATA_W-1:0]  data
);

    logic signed [olar_pkg::DATA_W-1:0] data_reg;
    logic signed [olar_pkg::DATA_W-1:0] data_next;
    logic [olar_pkg::CNT_W-1:0]         pos;
    logic                               occupied;
    logic                               is_tail;

    assign pos       = olar_pkg::CNT_W'(idx);
    assign occupied  = pos < ctrl.count;
    assign is_tail   = (pos + olar_pkg::CNT_W'(1)) == ctrl.count;
    // a match here or in any cell nearer the head
    assign found_out = found_in | (occupied && (data_reg == ctrl.value));
    assign data      = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            olar_pkg::CELL_APPEND:
            begin
                if (pos == ctrl.count)
                begin
                    data_next = ctrl.value;
                end
            end
            olar_pkg::CELL_REMOVE:
            begin
                // cells from the first match on close the gap
                if (found_out)
                begin
                    data_next = next_val;
                end
            end
            olar_pkg::CELL_ROTATE:
            begin
                data_next = is_tail ? head_val : next_val;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### hdl/olar_chain.sv
`timescale 1ns / 1ps
// row of DEPTH list cells, head at cell 0, with the match flag rippling tailward
// depends on olar_pkg and olar_cell

module olar_chain (
    input  logic                                clk,
    input  olar_pkg::cell_ctrl_t                ctrl,
    output logic                                found,
    output logic signed [olar_pkg::DATA_W-1:0]  head
);

    logic signed [olar_pkg::DATA_W-1:0] cell_data [olar_pkg::DEPTH];
    logic                               found_rip [olar_pkg::DEPTH+1];

    assign found_rip[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < olar_pkg::DEPTH; i++)
        begin : g_cell
            logic signed [olar_pkg::DATA_W-1:0] nbr;
            if (i == olar_pkg::DEPTH - 1)
            begin : g_end
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = cell_data[i+1];
            end

            olar_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .idx       (olar_pkg::IDX_W'(i)),
                .next_val  (nbr),
                .head_val  (cell_data[0]),
                .found_in  (found_rip[i]),
                .found_out (found_rip[i+1]),
                .data      (cell_data[i])
            );
        end
    endgenerate

    assign found = found_rip[olar_pkg::DEPTH];
    assign head  = cell_data[0];

endmodule

### hdl/ordered_list_append_remove.sv
`timescale 1ns / 1ps
// ordered list with append, remove-by-value and show, top level
// depends on olar_pkg, olar_req_if, olar_rsp_if and olar_chain
//
// usage:
//   req carries command (0 append, 1 remove, 2 show) and value; rsp carries
//   status, element and last. both use valid/ready, a transfer at each edge
//   with valid and ready high.
//   append and remove are done in the cycle of the request transfer; their
//   single result is loaded into the output register at that transfer.
//   show rotates the cell chain once per cycle while the output register is
//   free: the head goes out and the tail cell takes it back, so after count
//   rotations the list is as before. a show of n entries gives n results,
//   last on the final one; an empty list gives one empty status.
//   throughput: an append or remove every cycle while rsp.ready is high; a
//   show of n entries holds off req until its final result is loaded.
//   one command at a time: req.ready is low during a show and while a
//   result waits in the output register and rsp.ready is low.
//   a stalled receiver simply holds the output register and pauses the show.
//   reset empties the list (count to zero) and drops any pending result;
//   stored values are not cleared, only ever read below count.

module ordered_list_append_remove (
    input  logic            clk,
    input  logic            rst_n,
    olar_req_if.sink        req,
    olar_rsp_if.source      rsp
);

    olar_pkg::olar_state_t              state_reg, state_next;
    logic [olar_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [olar_pkg::IDX_W-1:0]         show_idx_reg, show_idx_next;
    logic                               out_valid_reg, out_valid_next;
    logic [2:0]                         out_status_reg, out_status_next;
    logic signed [olar_pkg::DATA_W-1:0] out_elem_reg, out_elem_next;
    logic                               out_last_reg, out_last_next;

    olar_pkg::cell_ctrl_t               ctrl;
    logic                               found;
    logic signed [olar_pkg::DATA_W-1:0] head;
    logic                               out_free;
    logic                               accept;
    logic                               out_load;
    logic                               show_last;

    olar_chain u_chain (
        .clk   (clk),
        .ctrl  (ctrl),
        .found (found),
        .head  (head)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == olar_pkg::S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign show_last = (olar_pkg::CNT_W'(show_idx_reg) + olar_pkg::CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        show_idx_next   = show_idx_reg;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_elem_next   = out_elem_reg;
        out_last_next   = out_last_reg;
        ctrl.op         = olar_pkg::CELL_HOLD;
        ctrl.count      = count_reg;
        ctrl.value      = req.value;

        unique case (state_reg)
            olar_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    out_elem_next = req.value;
                    out_last_next = 1'b1;
                    unique case (req.command)
                        olar_pkg::CMD_APPEND:
                        begin
                            out_load = 1'b1;
                            if (count_reg == olar_pkg::CNT_W'(olar_pkg::DEPTH))
                            begin
                                out_status_next = olar_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.op         = olar_pkg::CELL_APPEND;
                                count_next      = count_reg + olar_pkg::CNT_W'(1);
                                out_status_next = olar_pkg::ST_ADDED;
                            end
                        end
                        olar_pkg::CMD_REMOVE:
                        begin
                            out_load = 1'b1;
                            if (count_reg == '0)
                            begin
                                out_status_next = olar_pkg::ST_EMPTY;
                            end
                            else if (found)
                            begin
                                ctrl.op         = olar_pkg::CELL_REMOVE;
                                count_next      = count_reg - olar_pkg::CNT_W'(1);
                                out_status_next = olar_pkg::ST_REMOVED;
                            end
                            else
                            begin
                                out_status_next = olar_pkg::ST_NOT_FOUND;
                            end
                        end
                        olar_pkg::CMD_SHOW:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load        = 1'b1;
                                out_status_next = olar_pkg::ST_EMPTY;
                                out_elem_next   = '0;
                            end
                            else
                            begin
                                state_next    = olar_pkg::S_SHOW;
                                show_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            // unused code: no result, no change
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            olar_pkg::S_SHOW:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = olar_pkg::ST_LISTED;
                    out_elem_next   = head;
                    out_last_next   = show_last;
                    ctrl.op         = olar_pkg::CELL_ROTATE;
                    show_idx_next   = show_idx_reg + olar_pkg::IDX_W'(1);
                    if (show_last)
                    begin
                        state_next    = olar_pkg::S_IDLE;
                        show_idx_next = show_idx_reg;
                    end
                end
            end
            default:
            begin
                state_next = olar_pkg::S_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olar_pkg::S_IDLE;
            count_reg     <= '0;
            show_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            show_idx_reg  <= show_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_elem_reg   <= out_elem_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.element = out_elem_reg;
    assign rsp.last    = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= olar_pkg::CNT_W'(olar_pkg::DEPTH))
        else $error("list count beyond depth");

    a_count_only_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("list count changed without a request transfer");

    a_show_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == olar_pkg::S_SHOW) |->
            (olar_pkg::CNT_W'(show_idx_reg) < count_reg))
        else $error("show index past the tail");

    a_show_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == olar_pkg::S_SHOW && state_next == olar_pkg::S_IDLE) |=>
            (out_valid_reg && out_last_reg))
        else $error("show finished without a last result");

endmodule
